// ===== rtl/snmp_rec_pkg.sv =====
// ----------------------------------------------------------------------------
// SNMP payload recognizer package
// Shared types and BER constants for the SNMP payload recognizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snmp_rec_pkg;

   localparam logic [7:0] T_INT    = 8'h02;
   localparam logic [7:0] T_OCT    = 8'h04;
   localparam logic [7:0] T_NULL   = 8'h05;
   localparam logic [7:0] T_OBID   = 8'h06;
   localparam logic [7:0] T_SEQ    = 8'h30;
   localparam logic [7:0] T_GETREQ = 8'ha0;
   localparam logic [7:0] T_GETRES = 8'ha2;
   localparam logic [7:0] T_SETREQ = 8'ha3;

   localparam logic [7:0] ERR_STATUS_MAX = 8'd5;
   localparam logic [7:0] FLAGS_MAX      = 8'd7;
   localparam logic [7:0] VERSION_1      = 8'd0;
   localparam logic [7:0] VERSION_2C     = 8'd1;
   localparam logic [7:0] VERSION_3      = 8'd3;
   localparam logic [7:0] LEN_ONE        = 8'd1;
   localparam logic [7:0] LEN_TWO        = 8'd2;
   localparam logic [7:0] LEN_FOUR       = 8'd4;

   typedef enum logic [1:0] {
      VERDICT_PENDING = 2'd0,
      VERDICT_MATCH   = 2'd1,
      VERDICT_FAIL    = 2'd2
   } verdict_type;

   typedef enum logic [5:0] {
      ST_TYPE      = 6'd0,
      ST_LEN       = 6'd1,
      ST_VER_TAG   = 6'd2,
      ST_VER_LEN   = 6'd3,
      ST_VER       = 6'd4,
      ST_COMM_TAG  = 6'd5,
      ST_COMM_LEN  = 6'd6,
      ST_COMM_SKIP = 6'd7,
      ST_PDU_TYPE  = 6'd8,
      ST_PDU_LEN   = 6'd9,
      ST_RID_TAG   = 6'd10,
      ST_RID_LEN   = 6'd11,
      ST_RID_SKIP  = 6'd12,
      ST_ERR_TAG   = 6'd13,
      ST_ERR_LEN   = 6'd14,
      ST_ERR       = 6'd15,
      ST_EIDX_TAG  = 6'd16,
      ST_EIDX_LEN  = 6'd17,
      ST_EIDX      = 6'd18,
      ST_VB_TAG    = 6'd19,
      ST_VB_LEN    = 6'd20,
      ST_HDR_TAG   = 6'd21,
      ST_HDR_LEN   = 6'd22,
      ST_MID_TAG   = 6'd23,
      ST_MID_LEN   = 6'd24,
      ST_MID_SKIP  = 6'd25,
      ST_MAX_TAG   = 6'd26,
      ST_MAX_LEN   = 6'd27,
      ST_MAX_SKIP  = 6'd28,
      ST_FLG_TAG   = 6'd29,
      ST_FLG_LEN   = 6'd30,
      ST_FLG       = 6'd31,
      ST_FLG_SKIP  = 6'd32,
      ST_SMOD_TAG  = 6'd33,
      ST_SMOD_LEN  = 6'd34,
      ST_SMOD_SKIP = 6'd35,
      ST_SEC_TAG   = 6'd36,
      ST_SEC_LEN   = 6'd37,
      ST_SEC_BYTE  = 6'd38
   } step_type;

   typedef struct packed {
      logic       take;
      logic [7:0] data;
      logic       last;
   } beat_type;

endpackage

// ===== rtl/snmp_rec_parser.sv =====
// ----------------------------------------------------------------------------
// SNMP header parser
// Walks the BER header layout one byte per beat and tracks the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snmp_rec_parser
   import snmp_rec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  beat_type beat,
   output logic     matched
);

   step_type    step_ff, step_in;
   logic [7:0]  skip_ff, skip_in;
   verdict_type verdict_ff, verdict_in;

   step_type    step_c;
   logic [7:0]  skip_c;
   verdict_type verdict_c;
   logic [7:0]  b;
   logic        skip_done;

   assign b         = beat.data;
   assign skip_done = (skip_ff == 8'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_TYPE;
         skip_ff    <= 8'd0;
         verdict_ff <= VERDICT_PENDING;
      end else begin
         step_ff    <= step_in;
         skip_ff    <= skip_in;
         verdict_ff <= verdict_in;
      end
   end

   always_comb begin
      step_c    = step_ff;
      skip_c    = skip_ff;
      verdict_c = verdict_ff;
      if (verdict_ff == VERDICT_PENDING) begin
         unique case (step_ff)
            ST_TYPE: begin
               if (b == T_INT || b == T_OCT || b == T_NULL || b == T_OBID ||
                   b == T_SEQ || b == T_GETREQ || b == T_GETRES || b == T_SETREQ)
                  step_c = ST_LEN;
               else
                  verdict_c = VERDICT_FAIL;
            end
            ST_LEN: begin
               if (b != 8'd0) step_c = ST_VER_TAG;
               else verdict_c = VERDICT_FAIL;
            end
            ST_VER_TAG: begin
               if (b == T_INT) step_c = ST_VER_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_VER_LEN: begin
               if (b == LEN_ONE) step_c = ST_VER;
               else verdict_c = VERDICT_FAIL;
            end
            ST_VER: begin
               if (b == VERSION_1 || b == VERSION_2C) step_c = ST_COMM_TAG;
               else if (b == VERSION_3) step_c = ST_HDR_TAG;
               else verdict_c = VERDICT_FAIL;
            end
            ST_COMM_TAG: begin
               if (b == T_OCT) step_c = ST_COMM_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_COMM_LEN: begin
               skip_c = b;
               step_c = (b == 8'd0) ? ST_PDU_TYPE : ST_COMM_SKIP;
            end
            ST_COMM_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_PDU_TYPE;
            end
            ST_PDU_TYPE: begin
               if (b == T_GETREQ || b == T_GETRES || b == T_SETREQ) step_c = ST_PDU_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_PDU_LEN: begin
               if (b != 8'd0) step_c = ST_RID_TAG;
               else verdict_c = VERDICT_FAIL;
            end
            ST_RID_TAG: begin
               if (b == T_INT) step_c = ST_RID_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_RID_LEN: begin
               if (b == LEN_ONE || b == LEN_TWO || b == LEN_FOUR) begin
                  skip_c = b;
                  step_c = ST_RID_SKIP;
               end else begin
                  verdict_c = VERDICT_FAIL;
               end
            end
            ST_RID_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_ERR_TAG;
            end
            ST_ERR_TAG: begin
               if (b == T_INT) step_c = ST_ERR_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_ERR_LEN: begin
               if (b == LEN_ONE) step_c = ST_ERR;
               else verdict_c = VERDICT_FAIL;
            end
            ST_ERR: begin
               if (b <= ERR_STATUS_MAX) step_c = ST_EIDX_TAG;
               else verdict_c = VERDICT_FAIL;
            end
            ST_EIDX_TAG: begin
               if (b == T_INT) step_c = ST_EIDX_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_EIDX_LEN: begin
               if (b == LEN_ONE) step_c = ST_EIDX;
               else verdict_c = VERDICT_FAIL;
            end
            ST_EIDX: begin
               step_c = ST_VB_TAG;
            end
            ST_VB_TAG: begin
               if (b == T_SEQ) step_c = ST_VB_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_VB_LEN: begin
               verdict_c = (b != 8'd0) ? VERDICT_MATCH : VERDICT_FAIL;
            end
            ST_HDR_TAG: begin
               if (b == T_SEQ) step_c = ST_HDR_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_HDR_LEN: begin
               step_c = ST_MID_TAG;
            end
            ST_MID_TAG: begin
               if (b == T_INT) step_c = ST_MID_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_MID_LEN: begin
               if (b != 8'd0) begin
                  skip_c = b;
                  step_c = ST_MID_SKIP;
               end else begin
                  verdict_c = VERDICT_FAIL;
               end
            end
            ST_MID_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_MAX_TAG;
            end
            ST_MAX_TAG: begin
               if (b == T_INT) step_c = ST_MAX_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_MAX_LEN: begin
               if (b != 8'd0) begin
                  skip_c = b;
                  step_c = ST_MAX_SKIP;
               end else begin
                  verdict_c = VERDICT_FAIL;
               end
            end
            ST_MAX_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_FLG_TAG;
            end
            ST_FLG_TAG: begin
               if (b == T_OCT) step_c = ST_FLG_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_FLG_LEN: begin
               if (b == 8'd0) begin
                  verdict_c = VERDICT_FAIL;
               end else if (b == LEN_ONE) begin
                  step_c = ST_FLG;
               end else begin
                  skip_c = b;
                  step_c = ST_FLG_SKIP;
               end
            end
            ST_FLG: begin
               if (b <= FLAGS_MAX) step_c = ST_SMOD_TAG;
               else verdict_c = VERDICT_FAIL;
            end
            ST_FLG_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_SMOD_TAG;
            end
            ST_SMOD_TAG: begin
               if (b == T_INT) step_c = ST_SMOD_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_SMOD_LEN: begin
               skip_c = b;
               step_c = (b == 8'd0) ? ST_SEC_TAG : ST_SMOD_SKIP;
            end
            ST_SMOD_SKIP: begin
               skip_c = skip_ff - 8'd1;
               if (skip_done) step_c = ST_SEC_TAG;
            end
            ST_SEC_TAG: begin
               if (b == T_OCT) step_c = ST_SEC_LEN;
               else verdict_c = VERDICT_FAIL;
            end
            ST_SEC_LEN: begin
               if (b != 8'd0) step_c = ST_SEC_BYTE;
               else verdict_c = VERDICT_FAIL;
            end
            ST_SEC_BYTE: begin
               verdict_c = VERDICT_MATCH;
            end
            default: begin
               verdict_c = VERDICT_FAIL;
            end
         endcase
      end
   end

   always_comb begin
      step_in    = step_ff;
      skip_in    = skip_ff;
      verdict_in = verdict_ff;
      if (beat.take) begin
         if (beat.last) begin
            step_in    = ST_TYPE;
            skip_in    = 8'd0;
            verdict_in = VERDICT_PENDING;
         end else begin
            step_in    = step_c;
            skip_in    = skip_c;
            verdict_in = verdict_c;
         end
      end
   end

   assign matched = (verdict_c == VERDICT_MATCH);

endmodule

// ===== rtl/snmp_payload_recognizer.sv =====
// ----------------------------------------------------------------------------
// SNMP payload recognizer
// Checks a UDP payload, one byte per beat, against the SNMP BER header layout.
// ----------------------------------------------------------------------------
// The request channel carries one payload byte per beat, with req_last_byte
// marking the final byte of a payload. The response channel carries one beat
// per payload, sent after the final byte, with rsp_matched set when the
// payload was recognized as SNMP. Bytes before the final one give no beat.
// A request beat is taken into an input register; the parser reads that
// register and updates its state, and a final byte loads the response
// register as it leaves the input register.
// The block accepts one byte every cycle while no final byte is held back.
// Throughput is set by the single parser state update per byte.
// When the response register is full and rsp_stall is high, a final byte
// waiting in the input register holds, and req_stall rises until the
// response is taken. Other bytes keep flowing while the response waits.
// Reset clears both registers and returns the parser to the first type byte
// of a new payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snmp_payload_recognizer
   import snmp_rec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_matched_ff;
   logic       out_free;
   logic       advance;
   logic       parse_matched;
   beat_type   beat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;

   assign beat.take = advance;
   assign beat.data = in_byte_ff;
   assign beat.last = in_last_ff;

   snmp_rec_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .matched (parse_matched)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_matched_ff <= parse_matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

`ifndef SYNTH
   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked response");

   a_last_beat_gives_response: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("final byte consumed without a response");

   a_response_needs_last_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("response raised without a final byte");
`endif

endmodule

// ===== dv/snmp_rec_checker.sv =====
// ----------------------------------------------------------------------------
// SNMP payload recognizer checker
// Watches the request and response channels and predicts the match bit of
// each payload from the accepted bytes. It compares every response beat
// with the oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snmp_rec_checker
   import snmp_rec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_matched,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      step_type    step;
      logic [7:0]  skip;
      verdict_type verdict;
      logic [1:0]  ver;
   } parse_state_type;

   localparam parse_state_type PARSE_IDLE = '{
      step: ST_TYPE, skip: 8'd0, verdict: VERDICT_PENDING, ver: 2'd0
   };

   parse_state_type parse;
   bit              expected_matches[$];
   int              mismatches;

   function automatic parse_state_type next_parse_state(parse_state_type s,
                                                        logic [7:0] b);
      parse_state_type n;
      n = s;
      case (s.step)
         ST_TYPE: begin
            case (b)
               T_INT, T_OCT, T_NULL, T_OBID, T_SEQ, T_GETREQ, T_GETRES, T_SETREQ:
                  n.step = ST_LEN;
               default: n.verdict = VERDICT_FAIL;
            endcase
         end
         ST_LEN:      if (b != 8'd0) n.step = ST_VER_TAG; else n.verdict = VERDICT_FAIL;
         ST_VER_TAG:  if (b == T_INT) n.step = ST_VER_LEN; else n.verdict = VERDICT_FAIL;
         ST_VER_LEN:  if (b == LEN_ONE) n.step = ST_VER; else n.verdict = VERDICT_FAIL;
         ST_VER: begin
            if (b == VERSION_1 || b == VERSION_2C) begin
               n.ver  = b[1:0];
               n.step = ST_COMM_TAG;
            end else if (b == VERSION_3) begin
               n.ver  = 2'd3;
               n.step = ST_HDR_TAG;
            end else begin
               n.verdict = VERDICT_FAIL;
            end
         end
         ST_COMM_TAG: if (b == T_OCT) n.step = ST_COMM_LEN; else n.verdict = VERDICT_FAIL;
         ST_COMM_LEN: begin
            n.skip = b;
            n.step = (b == 8'd0) ? ST_PDU_TYPE : ST_COMM_SKIP;
         end
         ST_COMM_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_PDU_TYPE;
         end
         ST_PDU_TYPE: begin
            if (b == T_GETREQ || b == T_GETRES || b == T_SETREQ) n.step = ST_PDU_LEN;
            else n.verdict = VERDICT_FAIL;
         end
         ST_PDU_LEN:  if (b != 8'd0) n.step = ST_RID_TAG; else n.verdict = VERDICT_FAIL;
         ST_RID_TAG:  if (b == T_INT) n.step = ST_RID_LEN; else n.verdict = VERDICT_FAIL;
         ST_RID_LEN: begin
            if (b == LEN_ONE || b == LEN_TWO || b == LEN_FOUR) begin
               n.skip = b;
               n.step = ST_RID_SKIP;
            end else begin
               n.verdict = VERDICT_FAIL;
            end
         end
         ST_RID_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_ERR_TAG;
         end
         ST_ERR_TAG:  if (b == T_INT) n.step = ST_ERR_LEN; else n.verdict = VERDICT_FAIL;
         ST_ERR_LEN:  if (b == LEN_ONE) n.step = ST_ERR; else n.verdict = VERDICT_FAIL;
         ST_ERR:      if (b <= ERR_STATUS_MAX) n.step = ST_EIDX_TAG; else n.verdict = VERDICT_FAIL;
         ST_EIDX_TAG: if (b == T_INT) n.step = ST_EIDX_LEN; else n.verdict = VERDICT_FAIL;
         ST_EIDX_LEN: if (b == LEN_ONE) n.step = ST_EIDX; else n.verdict = VERDICT_FAIL;
         ST_EIDX:     n.step = ST_VB_TAG;
         ST_VB_TAG:   if (b == T_SEQ) n.step = ST_VB_LEN; else n.verdict = VERDICT_FAIL;
         ST_VB_LEN:   n.verdict = (b != 8'd0) ? VERDICT_MATCH : VERDICT_FAIL;
         ST_HDR_TAG:  if (b == T_SEQ) n.step = ST_HDR_LEN; else n.verdict = VERDICT_FAIL;
         ST_HDR_LEN:  n.step = ST_MID_TAG;
         ST_MID_TAG:  if (b == T_INT) n.step = ST_MID_LEN; else n.verdict = VERDICT_FAIL;
         ST_MID_LEN: begin
            if (b != 8'd0) begin
               n.skip = b;
               n.step = ST_MID_SKIP;
            end else begin
               n.verdict = VERDICT_FAIL;
            end
         end
         ST_MID_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_MAX_TAG;
         end
         ST_MAX_TAG:  if (b == T_INT) n.step = ST_MAX_LEN; else n.verdict = VERDICT_FAIL;
         ST_MAX_LEN: begin
            if (b != 8'd0) begin
               n.skip = b;
               n.step = ST_MAX_SKIP;
            end else begin
               n.verdict = VERDICT_FAIL;
            end
         end
         ST_MAX_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_FLG_TAG;
         end
         ST_FLG_TAG:  if (b == T_OCT) n.step = ST_FLG_LEN; else n.verdict = VERDICT_FAIL;
         ST_FLG_LEN: begin
            if (b == 8'd0) begin
               n.verdict = VERDICT_FAIL;
            end else if (b == LEN_ONE) begin
               n.step = ST_FLG;
            end else begin
               n.skip = b;
               n.step = ST_FLG_SKIP;
            end
         end
         ST_FLG:      if (b <= FLAGS_MAX) n.step = ST_SMOD_TAG; else n.verdict = VERDICT_FAIL;
         ST_FLG_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_SMOD_TAG;
         end
         ST_SMOD_TAG: if (b == T_INT) n.step = ST_SMOD_LEN; else n.verdict = VERDICT_FAIL;
         ST_SMOD_LEN: begin
            n.skip = b;
            n.step = (b == 8'd0) ? ST_SEC_TAG : ST_SMOD_SKIP;
         end
         ST_SMOD_SKIP: begin
            n.skip = s.skip - 8'd1;
            if (n.skip == 8'd0) n.step = ST_SEC_TAG;
         end
         ST_SEC_TAG:  if (b == T_OCT) n.step = ST_SEC_LEN; else n.verdict = VERDICT_FAIL;
         ST_SEC_LEN:  if (b != 8'd0) n.step = ST_SEC_BYTE; else n.verdict = VERDICT_FAIL;
         ST_SEC_BYTE: n.verdict = VERDICT_MATCH;
         default:     n.verdict = VERDICT_FAIL;
      endcase
      return n;
   endfunction

   initial begin
      parse         = PARSE_IDLE;
      mismatches    = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         parse = PARSE_IDLE;
         expected_matches.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (parse.verdict == VERDICT_PENDING) begin
               parse = next_parse_state(parse, req_payload_byte);
            end
            if (req_last_byte) begin
               expected_matches.push_back(parse.verdict == VERDICT_MATCH);
               parse = PARSE_IDLE;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $error("rsp_matched: expected no beat, actual %0b", rsp_matched);
               mismatches++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_matched !== want) begin
                  $error("rsp_matched: expected %0b, actual %0b", want, rsp_matched);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_matches.size();
   end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// SNMP payload recognizer testbench
// Sends directed and random payloads, both well formed SNMP headers of each
// version and broken, truncated or noisy ones, with random idle bursts on
// both channels and one long response hold. The checker predicts the match
// bit of each payload; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import snmp_rec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_payload_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_matched;
   int         fail_count;
   int         pending_count;

   logic [7:0] frame_bytes[$];
   int         bytes_sent;
   int         frames_sent;
   bit         gaps_on;
   bit         rsp_idle_on;
   bit         hold_go;
   bit         hold_done;
   bit         quiet_tail;

   snmp_payload_recognizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched)
   );

   snmp_rec_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void push_byte(logic [7:0] b);
      frame_bytes.push_back(b);
   endfunction

   function automatic void push_random(int n);
      for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] pick_lead_tag();
      case ($urandom_range(0, 7))
         0: return T_INT;
         1: return T_OCT;
         2: return T_NULL;
         3: return T_OBID;
         4: return T_SEQ;
         5: return T_GETREQ;
         6: return T_GETRES;
         default: return T_SETREQ;
      endcase
   endfunction

   function automatic int pick_len(int low);
      if ($urandom_range(0, 39) == 0) return 255;
      if ($urandom_range(0, 19) == 0) return 0;
      return $urandom_range(low, 6);
   endfunction

   function automatic void add_v12(logic [7:0] ver, int comm_len, logic [7:0] pdu,
                                   logic [7:0] rid_len, logic [7:0] err_status);
      push_byte(pick_lead_tag());
      push_byte(8'($urandom_range(1, 255)));
      push_byte(T_INT);
      push_byte(LEN_ONE);
      push_byte(ver);
      push_byte(T_OCT);
      push_byte(comm_len[7:0]);
      push_random(comm_len);
      push_byte(pdu);
      push_byte(8'($urandom_range(1, 255)));
      push_byte(T_INT);
      push_byte(rid_len);
      push_random(int'(rid_len));
      push_byte(T_INT);
      push_byte(LEN_ONE);
      push_byte(err_status);
      push_byte(T_INT);
      push_byte(LEN_ONE);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(T_SEQ);
      push_byte(8'($urandom_range(1, 255)));
   endfunction

   function automatic void add_v3(int mid_len, int max_len, logic [7:0] flg_len,
                                  logic [7:0] flg, int smod_len);
      push_byte(pick_lead_tag());
      push_byte(8'($urandom_range(1, 255)));
      push_byte(T_INT);
      push_byte(LEN_ONE);
      push_byte(VERSION_3);
      push_byte(T_SEQ);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(T_INT);
      push_byte(mid_len[7:0]);
      push_random(mid_len);
      push_byte(T_INT);
      push_byte(max_len[7:0]);
      push_random(max_len);
      push_byte(T_OCT);
      push_byte(flg_len);
      if (flg_len == LEN_ONE) push_byte(flg);
      else push_random(int'(flg_len));
      push_byte(T_INT);
      push_byte(smod_len[7:0]);
      push_random(smod_len);
      push_byte(T_OCT);
      push_byte(8'($urandom_range(1, 255)));
      push_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_random_v12();
      logic [7:0] ver;
      logic [7:0] pdu;
      logic [7:0] rid_len;
      logic [7:0] err_status;
      ver = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
            8'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: pdu = 8'($urandom_range(0, 255));
         1, 2, 3: pdu = T_GETREQ;
         4, 5, 6: pdu = T_GETRES;
         default: pdu = T_SETREQ;
      endcase
      case ($urandom_range(0, 7))
         0: rid_len = LEN_ONE;
         1, 2: rid_len = LEN_TWO;
         3, 4, 5: rid_len = LEN_FOUR;
         default: rid_len = 8'($urandom_range(0, 5));
      endcase
      err_status = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(6, 255)) :
                   8'($urandom_range(0, 5));
      add_v12(ver, pick_len(0), pdu, rid_len, err_status);
   endfunction

   function automatic void add_random_v3();
      logic [7:0] flg_len;
      logic [7:0] flg;
      case ($urandom_range(0, 9))
         0: flg_len = 8'd0;
         1, 2, 3: flg_len = 8'($urandom_range(2, 4));
         default: flg_len = LEN_ONE;
      endcase
      flg = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8, 255)) :
            8'($urandom_range(0, 7));
      add_v3(pick_len(1), pick_len(1), flg_len, flg, pick_len(0));
   endfunction

   task automatic send_byte(logic [7:0] b, logic is_last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= b;
      req_last_byte    <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame();
      int n;
      n = frame_bytes.size();
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
      bytes_sent += n;
      frames_sent++;
      frame_bytes.delete();
   endtask

   initial begin
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int kind;
      int cut;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload_byte = 8'd0;
      req_last_byte    = 1'b0;
      bytes_sent       = 0;
      frames_sent      = 0;
      gaps_on          = 1'b0;
      rsp_idle_on      = 1'b0;
      hold_go          = 1'b0;
      quiet_tail       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_v12(VERSION_1, 0, T_GETREQ, LEN_ONE, 8'd0);
      send_frame();
      add_v12(VERSION_2C, 3, T_GETRES, LEN_TWO, ERR_STATUS_MAX);
      send_frame();
      add_v12(VERSION_2C, 1, T_SETREQ, LEN_FOUR, ERR_STATUS_MAX + 8'd1);
      send_frame();
      add_v12(VERSION_1, 2, T_GETREQ, 8'd0, 8'd0);
      send_frame();
      add_v12(VERSION_1, 255, T_SETREQ, LEN_ONE, 8'd1);
      send_frame();
      add_v3(1, 2, LEN_ONE, FLAGS_MAX, 0);
      send_frame();
      add_v3(2, 1, LEN_ONE, FLAGS_MAX + 8'd1, 1);
      send_frame();
      add_v3(1, 1, 8'd3, 8'd0, 2);
      send_frame();
      add_v12(VERSION_2C, 1, T_GETRES, LEN_ONE, 8'd2);
      void'(frame_bytes.pop_back());
      send_frame();
      push_byte(T_SEQ);
      send_frame();
      push_byte(8'hff);
      send_frame();
      push_byte(8'h00);
      send_frame();
      push_byte(T_SEQ);
      push_byte(8'hff);
      push_byte(T_INT);
      push_byte(LEN_ONE);
      push_byte(8'd2);
      push_byte(8'h00);
      push_byte(8'hff);
      send_frame();

      gaps_on     = 1'b1;
      rsp_idle_on = 1'b1;
      while (bytes_sent < 1600 || frames_sent < 24) begin
         if (frames_sent == 20) hold_go = 1'b1;
         if (bytes_sent > 1350) quiet_tail = 1'b1;
         if (quiet_tail || (frames_sent >= 20 && frames_sent < 26)) begin
            gaps_on     = 1'b0;
            rsp_idle_on = 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            gaps_on     = $urandom_range(0, 2) != 0;
            rsp_idle_on = $urandom_range(0, 2) != 0;
         end
         kind = $urandom_range(0, 99);
         if (kind < 95) begin
            if ($urandom_range(0, 1) == 0) add_random_v12();
            else add_random_v3();
         end else begin
            push_random($urandom_range(1, 8));
         end
         if (kind >= 65 && kind < 85) begin
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
               8'($urandom_range(0, 255));
         end else if (kind >= 85 && kind < 95) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
         if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, 4));
         send_frame();
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
